// ----- design/hwde_pkg.sv -----
`default_nettype none
package hwde_pkg;

   // Default sizes of the block.
   localparam int MAX_HITS_DEF          = 64;
   localparam int PADS_PER_STRIP_DEF    = 96;
   localparam int BUNCHES_PER_ORBIT_DEF = 3564;

   // Reciprocal shift used for the channel to strip split.
   localparam int RECIP_SHIFT = 27;

   // Request commands; the unused code is accepted and ignored.
   typedef enum logic [1:0] {
      CMD_FIRST_WINDOW = 2'd0,
      CMD_WINDOW       = 2'd1,
      CMD_HIT          = 2'd2,
      CMD_UNUSED       = 2'd3
   } cmd_type;

   // Record kinds.
   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_HIT    = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] orbit;
      logic [11:0] bunch;
      logic [6:0]  hit_count;
      logic [43:0] hit_bunch;
      logic [9:0]  tdc;
      logic [17:0] channel;
      logic [15:0] tot;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] orbit_inc;
      logic [11:0] bunch_code;
      logic [6:0]  window_hits;
      logic [9:0]  frame_inc;
      logic [15:0] time_code;
      logic [11:0] strip;
      logic [6:0]  pad;
      logic [15:0] hit_tot;
      logic        last;
   } rsp_type;

   // One stored hit; bunch and tdc together form the sort key.
   typedef struct packed {
      logic [43:0] bunch;
      logic [9:0]  tdc;
      logic [17:0] channel;
      logic [15:0] tot;
   } hit_entry_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- design/hit_window_delta_encoder_core.sv -----
// Channel   Ports                           Direction   Payload
// request   req_valid req_stall req_data    in          req_type
// response  rsp_valid rsp_stall rsp_data    out         rsp_type
//
// A window request gives its record from a register in the cycle after it is accepted.
// Each expected hit request is sorted into the cell chain and gives nothing.
// The last expected hit starts a drain: N hit records leave the chain head one per
// cycle, unless the response stalls, through two registers; requests stall while it runs.
// Reset empties the chain and clears all window and frame state.
// A stalled response holds the drain and stalls requests.
`default_nettype none
module hit_window_delta_encoder_core
   import hwde_pkg::*;
#(
   parameter int MAX_HITS          = MAX_HITS_DEF,
   parameter int PADS_PER_STRIP    = PADS_PER_STRIP_DEF,
   parameter int BUNCHES_PER_ORBIT = BUNCHES_PER_ORBIT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CW   = $clog2(MAX_HITS + 1);
   localparam int RECIP = (1 << RECIP_SHIFT) / PADS_PER_STRIP;
   localparam int MW   = RECIP_SHIFT + 1;

   logic [31:0]   prev_orbit_ff;
   logic [11:0]   prev_bunch_ff;
   logic [43:0]   window_start_ff;
   logic [CW-1:0] hits_expected_ff, hits_loaded_ff;
   logic [9:0]    current_frame_ff;
   logic [15:0]   previous_time_ff;
   logic          drain_ff;

   logic                 s1_valid_ff, s1_last_ff;
   logic [9:0]           s1_frame_ff;
   logic [15:0]          s1_fine_ff, s1_tot_ff;
   logic [17:0]          s1_channel_ff;
   logic [18+MW-1:0]     s1_prod_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic          adv, busy, acc, acc_window, acc_hit, do_insert;
   cell_ctrl_type ctrl;
   hit_entry_type new_hit, head_hit;
   logic          head_valid, next_valid;

   // Handshake and sequencing.
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign busy       = drain_ff || s1_valid_ff;
   assign req_stall  = busy || !adv;
   assign acc        = req_valid && !req_stall;
   assign acc_window = acc && (req_data.command == CMD_FIRST_WINDOW ||
                               req_data.command == CMD_WINDOW);
   assign acc_hit    = acc && (req_data.command == CMD_HIT);
   assign do_insert  = acc_hit && (hits_loaded_ff < hits_expected_ff);

   assign ctrl.clear  = acc_window;
   assign ctrl.insert = do_insert;
   assign ctrl.shift  = drain_ff && adv;

   assign new_hit.bunch   = req_data.hit_bunch;
   assign new_hit.tdc     = req_data.tdc;
   assign new_hit.channel = req_data.channel;
   assign new_hit.tot     = req_data.tot;

   hwde_chain #(.MAX_HITS(MAX_HITS)) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_hit    (new_hit),
      .head_hit   (head_hit),
      .head_valid (head_valid),
      .next_valid (next_valid)
   );

   // Window record.
   logic [31:0]   w_prev_orbit;
   logic [11:0]   w_prev_bunch;
   logic          w_same;
   rsp_type       w_rsp;
   logic [43:0]   w_start;
   logic [CW-1:0] w_expected;

   always_comb begin
      w_prev_orbit = (req_data.command == CMD_FIRST_WINDOW) ? req_data.orbit : prev_orbit_ff;
      w_prev_bunch = (req_data.command == CMD_FIRST_WINDOW) ? req_data.bunch : prev_bunch_ff;
      w_same       = (req_data.orbit == w_prev_orbit);
      w_rsp             = '0;
      w_rsp.kind        = KIND_WINDOW;
      w_rsp.orbit_inc   = w_same ? 32'd0 : req_data.orbit - w_prev_orbit;
      w_rsp.bunch_code  = w_same ? req_data.bunch - w_prev_bunch : req_data.bunch;
      w_rsp.window_hits = req_data.hit_count;
      w_rsp.last        = 1'b1;
      w_start    = ({12'd0, req_data.orbit} * 44'(BUNCHES_PER_ORBIT)) + 44'(req_data.bunch);
      w_expected = (int'(req_data.hit_count) > MAX_HITS) ? CW'(MAX_HITS)
                                                         : CW'(req_data.hit_count);
   end

   // Stage 1: offset from the window start and the strip reciprocal product.
   logic [44:0]   h_diff;
   logic [15:0]   h_off;

   always_comb begin
      h_diff = {1'b0, head_hit.bunch} - {1'b0, window_start_ff};
      if (h_diff[44]) begin
         h_off = 16'd0;
      end else if (h_diff[43:16] != '0) begin
         h_off = 16'hFFFF;
      end else begin
         h_off = h_diff[15:0];
      end
   end

   // Stage 2: frame and time deltas, quotient correction.
   logic [17:0] q_est, rem, q_fix, rem_fix;
   logic [26:0] q_mul;
   logic        h_same;
   rsp_type     h_rsp;

   always_comb begin
      q_est   = 18'(s1_prod_ff >> RECIP_SHIFT);
      q_mul   = 27'(q_est) * 27'(PADS_PER_STRIP);
      rem     = s1_channel_ff - q_mul[17:0];
      if (rem >= 18'(PADS_PER_STRIP)) begin
         q_fix   = q_est + 18'd1;
         rem_fix = rem - 18'(PADS_PER_STRIP);
      end else begin
         q_fix   = q_est;
         rem_fix = rem;
      end
      h_same          = (s1_frame_ff == current_frame_ff);
      h_rsp           = '0;
      h_rsp.kind      = KIND_HIT;
      h_rsp.frame_inc = h_same ? 10'd0 : s1_frame_ff - current_frame_ff;
      h_rsp.time_code = h_same ? s1_fine_ff - previous_time_ff : s1_fine_ff;
      h_rsp.strip     = q_fix[11:0];
      h_rsp.pad       = rem_fix[6:0];
      h_rsp.hit_tot   = s1_tot_ff;
      h_rsp.last      = s1_last_ff;
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff    <= !next_valid;
         s1_frame_ff   <= h_off[15:6];
         s1_fine_ff    <= {h_off[5:0], head_hit.tdc};
         s1_tot_ff     <= head_hit.tot;
         s1_channel_ff <= head_hit.channel;
         s1_prod_ff    <= (18+MW)'(head_hit.channel) * (18+MW)'(RECIP);
         if (acc_window) begin
            rsp_data_ff <= w_rsp;
         end else if (s1_valid_ff) begin
            rsp_data_ff <= h_rsp;
         end
      end
   end

   // Control and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_orbit_ff    <= '0;
         prev_bunch_ff    <= '0;
         window_start_ff  <= '0;
         hits_expected_ff <= '0;
         hits_loaded_ff   <= '0;
         current_frame_ff <= '0;
         previous_time_ff <= '0;
         drain_ff         <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (acc_window) begin
            prev_orbit_ff    <= req_data.orbit;
            prev_bunch_ff    <= req_data.bunch;
            window_start_ff  <= w_start;
            hits_expected_ff <= w_expected;
            hits_loaded_ff   <= '0;
            current_frame_ff <= '0;
            previous_time_ff <= '0;
         end else if (do_insert) begin
            if (hits_loaded_ff + CW'(1) == hits_expected_ff) begin
               hits_loaded_ff   <= '0;
               hits_expected_ff <= '0;
               drain_ff         <= 1'b1;
            end else begin
               hits_loaded_ff <= hits_loaded_ff + CW'(1);
            end
         end
         if (adv) begin
            s1_valid_ff  <= drain_ff && head_valid;
            rsp_valid_ff <= acc_window || s1_valid_ff;
            if (drain_ff && !next_valid) begin
               drain_ff <= 1'b0;
            end
            if (s1_valid_ff) begin
               current_frame_ff <= s1_frame_ff;
               previous_time_ff <= s1_fine_ff;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // No request is taken while the chain drains.
   a_no_accept_in_drain: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> req_stall)
      else $error("request accepted during drain");

   // The load count never passes the expected count.
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      hits_loaded_ff <= hits_expected_ff)
      else $error("hit load count overran");

   // A window record always closes its request.
   a_window_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_WINDOW) |-> rsp_data.last)
      else $error("window record without last");
`endif

endmodule
`default_nettype wire

// ----- design/hwde_cell.sv -----
`default_nettype none
module hwde_cell
   import hwde_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire hit_entry_type new_hit,
   input  wire hit_entry_type left_hit,
   input  wire logic          left_valid,
   input  wire logic          left_gt,
   input  wire hit_entry_type right_hit,
   input  wire logic          right_valid,
   output hit_entry_type      hit,
   output logic               valid,
   output logic               gt
);

   hit_entry_type hit_ff, hit_in;
   logic          valid_ff, valid_in;

   // The stored key is strictly greater than the new one, so the new hit goes before it.
   assign gt = valid_ff && ({hit_ff.bunch, hit_ff.tdc} > {new_hit.bunch, new_hit.tdc});

   // Insert shifts greater entries one cell right; drain shifts everything left.
   always_comb begin
      hit_in   = hit_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert) begin
         if (gt || !valid_ff) begin
            if (left_gt) begin
               hit_in   = left_hit;
               valid_in = 1'b1;
            end else if (left_valid) begin
               hit_in   = new_hit;
               valid_in = 1'b1;
            end
         end
      end else if (ctrl.shift) begin
         hit_in   = right_hit;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign hit   = hit_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

// ----- design/hwde_chain.sv -----
`default_nettype none
module hwde_chain
   import hwde_pkg::*;
#(
   parameter int MAX_HITS = MAX_HITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire hit_entry_type new_hit,
   output hit_entry_type      head_hit,
   output logic               head_valid,
   output logic               next_valid
);

   hit_entry_type cell_hit [MAX_HITS];
   logic          cell_valid [MAX_HITS];
   logic          cell_gt [MAX_HITS];

   // A row of sorting cells; cell 0 holds the smallest key.
   for (genvar i = 0; i < MAX_HITS; i++) begin : g_cell
      hit_entry_type l_hit, r_hit;
      logic          l_valid, l_gt, r_valid;

      if (i == 0) begin : g_first
         assign l_hit   = new_hit;
         assign l_valid = 1'b1;
         assign l_gt    = 1'b0;
      end else begin : g_mid
         assign l_hit   = cell_hit[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_gt    = cell_gt[i-1];
      end

      if (i == MAX_HITS - 1) begin : g_end
         assign r_hit   = new_hit;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_hit   = cell_hit[i+1];
         assign r_valid = cell_valid[i+1];
      end

      hwde_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_hit     (new_hit),
         .left_hit    (l_hit),
         .left_valid  (l_valid),
         .left_gt     (l_gt),
         .right_hit   (r_hit),
         .right_valid (r_valid),
         .hit         (cell_hit[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   assign head_hit   = cell_hit[0];
   assign head_valid = cell_valid[0];

   if (MAX_HITS > 1) begin : g_next
      assign next_valid = cell_valid[1];
   end else begin : g_no_next
      assign next_valid = 1'b0;
   end

endmodule
`default_nettype wire

// ----- bench/hit_window_delta_encoder_core_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hit_window_delta_encoder_core_tb;
   import hwde_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int REQ_BITS = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   hit_window_delta_encoder_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // Requests waiting to be driven and records expected from the block.
   req_type pending_requests[$];
   rsp_type expected_records[$];

   // Predictor state.
   logic [31:0]   last_orbit;
   logic [11:0]   last_bunch;
   logic [43:0]   window_origin;
   int            hits_wanted;
   int            hits_held;
   hit_entry_type sorted_hits[$];
   logic [9:0]    frame_now;
   logic [15:0]   fine_now;

   int  mismatch_count;
   bit  stimulus_done;
   bit  quiet_mode;
   bit  hold_long;
   int  stall_left;
   int  gap_left;
   int  idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sort one hit into the window store; equal keys stay in arrival order.
   function automatic void insert_hit(input req_type r);
      hit_entry_type h;
      int pos;
      h.bunch = r.hit_bunch;
      h.tdc = r.tdc;
      h.channel = r.channel;
      h.tot = r.tot;
      pos = sorted_hits.size();
      while (pos > 0 && {sorted_hits[pos-1].bunch, sorted_hits[pos-1].tdc} > {h.bunch, h.tdc})
         pos--;
      sorted_hits.insert(pos, h);
   endfunction

   // Turn one sorted hit into its delta-coded record.
   function automatic rsp_type encode_hit(input hit_entry_type h, input bit is_last);
      rsp_type o;
      logic [43:0] off;
      logic [9:0]  frame;
      logic [15:0] fine;
      o = '0;
      o.kind = KIND_HIT;
      if (h.bunch >= window_origin) begin
         off = h.bunch - window_origin;
         if (off > 44'd65535) off = 44'd65535;
      end else begin
         off = '0;
      end
      frame = off[15:6];
      fine = {off[5:0], h.tdc};
      if (frame == frame_now) begin
         o.time_code = fine - fine_now;
      end else begin
         o.frame_inc = frame - frame_now;
         o.time_code = fine;
         frame_now = frame;
      end
      fine_now = fine;
      o.strip = 12'(h.channel / 96);
      o.pad = 7'(h.channel % 96);
      o.hit_tot = h.tot;
      o.last = is_last;
      return o;
   endfunction

   // Work out the records that one accepted request causes.
   function automatic void predict_records(input req_type r);
      rsp_type o;
      logic [63:0] abs_bunch;
      if (r.command == CMD_FIRST_WINDOW || r.command == CMD_WINDOW) begin
         if (r.command == CMD_FIRST_WINDOW) begin
            last_orbit = r.orbit;
            last_bunch = r.bunch;
         end
         o = '0;
         o.kind = KIND_WINDOW;
         if (r.orbit == last_orbit) begin
            o.bunch_code = r.bunch - last_bunch;
         end else begin
            o.orbit_inc = r.orbit - last_orbit;
            o.bunch_code = r.bunch;
            last_orbit = r.orbit;
         end
         last_bunch = r.bunch;
         o.window_hits = r.hit_count;
         o.last = 1'b1;
         expected_records.push_back(o);
         abs_bunch = 64'(r.orbit) * 64'd3564 + 64'(r.bunch);
         window_origin = abs_bunch[43:0];
         hits_wanted = (r.hit_count > 64) ? 64 : int'(r.hit_count);
         hits_held = 0;
         sorted_hits.delete();
         frame_now = '0;
         fine_now = '0;
      end else if (r.command == CMD_HIT) begin
         if (hits_held >= hits_wanted) return;
         insert_hit(r);
         hits_held++;
         if (hits_held < hits_wanted) return;
         foreach (sorted_hits[i])
            expected_records.push_back(encode_hit(sorted_hits[i], i == sorted_hits.size() - 1));
         sorted_hits.delete();
         hits_wanted = 0;
         hits_held = 0;
      end
   endfunction

   function automatic req_type random_noise();
      req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return r;
   endfunction

   function automatic req_type make_window(input cmd_type c, input logic [31:0] orb,
                                           input logic [11:0] bx, input int n);
      req_type r;
      r = random_noise();
      r.command = c;
      r.orbit = orb;
      r.bunch = bx;
      r.hit_count = 7'(n);
      return r;
   endfunction

   function automatic req_type make_hit(input logic [43:0] hb, input logic [9:0] t);
      req_type r;
      r = random_noise();
      r.command = CMD_HIT;
      r.hit_bunch = hb;
      r.tdc = t;
      return r;
   endfunction

   // Queue one window and its hits, most near its start, some before it, far after it or random.
   task automatic queue_window(input int n, input bit first);
      logic [31:0] orb;
      logic [11:0] bx;
      logic [63:0] base;
      logic [43:0] hb;
      orb = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 5));
      bx = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3563));
      pending_requests.push_back(make_window(first ? CMD_FIRST_WINDOW : CMD_WINDOW, orb, bx, n));
      base = 64'(orb) * 64'd3564 + 64'(bx);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: hb = 44'($urandom) << 12 | 44'($urandom);
            1: hb = base[43:0] - 44'($urandom_range(0, 3));
            2: hb = base[43:0] + 44'($urandom_range(65500, 70000));
            default: hb = base[43:0] + 44'($urandom_range(0, 300));
         endcase
         pending_requests.push_back(make_hit(hb, ($urandom_range(0, 3) == 0)
                                             ? 10'($urandom_range(0, 1)) : 10'($urandom)));
      end
   endtask

   // Stimulus: directed cases first, then random windows with some noise.
   initial begin
      int count;
      req_type r;
      reset = 1'b1;
      stimulus_done = 1'b0;
      quiet_mode = 1'b0;
      hold_long = 1'b0;
      // First window of a frame with extreme fields and a few hits with equal keys.
      pending_requests.push_back(make_window(CMD_FIRST_WINDOW, 32'hFFFF_FFFF, 12'hFFF, 4));
      r = make_hit(44'hFFF_FFFF_FFFF, 10'h3FF); r.channel = 18'h3FFFF; r.tot = 16'hFFFF;
      pending_requests.push_back(r);
      r = make_hit(44'h0, 10'h0); r.channel = '0; r.tot = '0;
      pending_requests.push_back(r);
      pending_requests.push_back(make_hit(44'hFFF_FFFF_FFFF, 10'h3FF));
      pending_requests.push_back(make_hit(44'h0, 10'h0));
      // Windows with no hits: same orbit, then an orbit change.
      pending_requests.push_back(make_window(CMD_WINDOW, 32'hFFFF_FFFF, 12'd5, 0));
      pending_requests.push_back(make_window(CMD_WINDOW, 32'd0, 12'd3563, 0));
      // Unexpected hit and the unused command.
      pending_requests.push_back(make_hit(44'd1, 10'd1));
      r = random_noise(); r.command = CMD_UNUSED;
      pending_requests.push_back(r);
      // Window abandoned before its hits all arrived.
      pending_requests.push_back(make_window(CMD_WINDOW, 32'd1, 12'd0, 3));
      pending_requests.push_back(make_hit(44'd3570, 10'd7));
      // Too many hits announced: the load saturates at the store size.
      pending_requests.push_back(make_window(CMD_WINDOW, 32'd1, 12'd10, 127));
      for (int i = 0; i < 64; i++)
         pending_requests.push_back(make_hit(44'd3574 + 44'($urandom_range(0, 200000)),
                                             10'($urandom)));
      pending_requests.push_back(make_hit(44'd5, 10'd5));
      count = 0;
      while (count < 130) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_requests.push_back(random_noise());
            count++;
         end else begin
            int n;
            n = ($urandom_range(0, 15) == 0) ? 64 : $urandom_range(0, 6);
            queue_window(n, $urandom_range(0, 3) == 0);
            count += n + 1;
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Hold the receiver off for a long stretch while requests keep coming.
      wait (expected_records.size() > 8);
      hold_long <= 1'b1;
      repeat (150) @(posedge clock);
      hold_long <= 1'b0;
      wait (pending_requests.size() < 40);
      quiet_mode <= 1'b1;
      wait (pending_requests.size() == 0 && !req_valid);
      stimulus_done <= 1'b1;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 15);
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall, in bursts, plus the long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_long) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on accepted requests, compare accepted records.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         last_orbit = '0;
         last_bunch = '0;
         window_origin = '0;
         hits_wanted = 0;
         hits_held = 0;
         sorted_hits.delete();
         frame_now = '0;
         fine_now = '0;
         mismatch_count = 0;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            predict_records(req_data);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (expected_records.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected record %p", rsp_data);
            end else begin
               want = expected_records.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("record mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
      end
   end

   // End of run and watchdog.
   initial begin
      wait (stimulus_done);
      while (expected_records.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT || expected_records.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("hit_window_delta_encoder_core_tb OK");
      else
         $display("hit_window_delta_encoder_core_tb NOT OK");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT && !stimulus_done);
      $display("hit_window_delta_encoder_core_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
design/hwde_pkg.sv
design/hwde_cell.sv
design/hwde_chain.sv
design/hit_window_delta_encoder_core.sv
bench/hit_window_delta_encoder_core_tb.sv
